/* hw/rtl/ppjs_pkg.sv */
// Package for the preemptive priority job scheduler.
// Holds sizing constants and the controller/datapath command and status structs.
package ppjs_pkg;

   localparam int WAIT_DEPTH = 16;
   localparam int SLOT_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

   typedef struct packed {
      logic load;      // latch a new input item
      logic finish;    // complete the running job, emit it, start a search
      logic reduce;    // running job absorbs all elapsed time
      logic step;      // examine one waiting slot
      logic dispatch;  // move the search winner to the processor
      logic place;     // settle the arriving job, or drop it
      logic flush;     // send the held result out as the item's last
   } ppjs_cmd_type;

   typedef struct packed {
      logic drain;
      logic run_valid;
      logic elapsed_zero;
      logic fin_ok;
      logic can_emit;
      logic held_valid;
      logic out_free;
      logic search_last;
   } ppjs_stat_type;

endpackage

/* hw/rtl/ppjs_req_if.sv */
// Input channel of the job scheduler: valid/ready plus one job item.
// Standalone interface, no dependencies.
interface ppjs_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] job_id;
   logic [31:0] arrival_time;
   logic [15:0] run_time;
   logic [7:0]  priority_req;

   modport source (output valid, req_type, job_id, arrival_time, run_time, priority_req,
                   input ready);
   modport sink   (input valid, req_type, job_id, arrival_time, run_time, priority_req,
                   output ready);
endinterface

/* hw/rtl/ppjs_rsp_if.sv */
// Result channel of the job scheduler: valid/ready plus one completion item.
// Standalone interface, no dependencies.
interface ppjs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] done_id;
   logic [31:0] finish_time;
   logic        last;
   logic        dropped;

   modport source (output valid, done_id, finish_time, last, dropped, input ready);
   modport sink   (input valid, done_id, finish_time, last, dropped, output ready);
endinterface

/* hw/rtl/ppjs_ctrl.sv */
// Scheduler controller: one-hot sequencer issuing datapath commands.
// Depends on ppjs_pkg.
module ppjs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ppjs_pkg::ppjs_stat_type st,
   output ppjs_pkg::ppjs_cmd_type  cmd
);
   import ppjs_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOP   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_DISP   = 6'b001000,
      S_PLACE  = 6'b010000,
      S_FLUSH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (st.run_valid && (st.drain || !st.elapsed_zero)) begin
               if (!st.fin_ok) begin
                  cmd.reduce = 1'b1;
               end else if (st.can_emit) begin
                  cmd.finish = 1'b1;
                  state_in   = S_SEARCH;
               end
            end else if (st.drain) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (st.search_last) state_in = S_DISP;
         end
         S_DISP: begin
            cmd.dispatch = 1'b1;
            state_in     = S_LOOP;
         end
         S_PLACE: begin
            if (st.can_emit) begin
               cmd.place = 1'b1;
               state_in  = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!st.held_valid) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* hw/rtl/ppjs_dp.sv */
// Scheduler datapath: time, running job, waiting slots, search and result staging.
// Depends on ppjs_pkg, ppjs_req_if, ppjs_rsp_if.
module ppjs_dp (
   input  logic                   clock,
   input  logic                   reset,
   ppjs_req_if.sink               req_if,
   ppjs_rsp_if.source             rsp_if,
   input  ppjs_pkg::ppjs_cmd_type  cmd,
   output ppjs_pkg::ppjs_stat_type st
);
   import ppjs_pkg::*;

   // latched item
   logic        drain_ff;
   logic [15:0] in_id_ff, in_run_ff;
   logic [31:0] in_arr_ff, target_ff, elapsed_ff;
   logic [7:0]  in_pri_ff;

   logic [31:0] now_ff;
   logic        run_valid_ff;
   logic [15:0] run_id_ff, run_rem_ff;
   logic [7:0]  run_pri_ff;
   logic [31:0] run_arr_ff;

   logic [WAIT_DEPTH-1:0] wait_valid_ff;
   logic [15:0] wait_id_ff  [WAIT_DEPTH];
   logic [15:0] wait_rem_ff [WAIT_DEPTH];
   logic [7:0]  wait_pri_ff [WAIT_DEPTH];
   logic [31:0] wait_arr_ff [WAIT_DEPTH];

   // search
   logic [SLOT_W-1:0] idx_ff, best_ff;
   logic              best_valid_ff;
   logic [15:0]       best_id_ff, best_rem_ff;
   logic [7:0]        best_pri_ff;
   logic [31:0]       best_arr_ff;

   // result staging: held result waits until we know whether it is the last
   logic        held_valid_ff;
   logic [15:0] held_id_ff;
   logic [31:0] held_time_ff;
   logic        held_drop_ff;
   logic        out_valid_ff;
   logic [15:0] out_id_ff;
   logic [31:0] out_time_ff;
   logic        out_last_ff, out_drop_ff;

   logic              out_free, full, cand_better, emit;
   logic [SLOT_W-1:0] free_slot;
   logic [15:0]       emit_id;
   logic [31:0]       emit_time, fin_time, elapsed_in;
   logic              emit_drop;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign fin_time = now_ff + {16'd0, run_rem_ff};

   always_comb begin
      free_slot = '0;
      full      = 1'b1;
      for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
         if (!wait_valid_ff[i]) begin
            free_slot = SLOT_W'(i);
            full      = 1'b0;
         end
      end
   end

   always_comb begin
      if (wait_pri_ff[idx_ff] != best_pri_ff)
         cand_better = wait_pri_ff[idx_ff] > best_pri_ff;
      else if (wait_arr_ff[idx_ff] != best_arr_ff)
         cand_better = wait_arr_ff[idx_ff] < best_arr_ff;
      else
         cand_better = wait_id_ff[idx_ff] < best_id_ff;
   end

   assign elapsed_in = (req_if.arrival_time > now_ff) ? req_if.arrival_time - now_ff : 32'd0;

   always_comb begin
      emit      = cmd.finish || (cmd.place && run_valid_ff && full);
      emit_id   = cmd.finish ? run_id_ff : 16'd0;
      emit_time = cmd.finish ? fin_time  : 32'd0;
      emit_drop = !cmd.finish;
   end

   always_comb begin
      st.drain        = drain_ff;
      st.run_valid    = run_valid_ff;
      st.elapsed_zero = (elapsed_ff == 32'd0);
      st.fin_ok       = drain_ff || ({16'd0, run_rem_ff} <= elapsed_ff);
      st.can_emit     = !held_valid_ff || out_free;
      st.held_valid   = held_valid_ff;
      st.out_free     = out_free;
      st.search_last  = (idx_ff == SLOT_W'(WAIT_DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drain_ff   <= req_if.req_type;
         in_id_ff   <= req_if.job_id;
         in_arr_ff  <= req_if.arrival_time;
         in_run_ff  <= (req_if.run_time == 16'd0) ? 16'd1 : req_if.run_time;
         in_pri_ff  <= req_if.priority_req;
         elapsed_ff <= elapsed_in;
         target_ff  <= now_ff + elapsed_in;
      end else if (cmd.finish) begin
         elapsed_ff <= drain_ff ? elapsed_ff : elapsed_ff - {16'd0, run_rem_ff};
      end else if (cmd.reduce) begin
         elapsed_ff <= 32'd0;
      end
      if (cmd.step && wait_valid_ff[idx_ff] && (!best_valid_ff || cand_better)) begin
         best_ff     <= idx_ff;
         best_id_ff  <= wait_id_ff[idx_ff];
         best_rem_ff <= wait_rem_ff[idx_ff];
         best_pri_ff <= wait_pri_ff[idx_ff];
         best_arr_ff <= wait_arr_ff[idx_ff];
      end
      if (cmd.place && run_valid_ff && !full) begin
         if (in_pri_ff > run_pri_ff) begin
            wait_id_ff[free_slot]  <= run_id_ff;
            wait_rem_ff[free_slot] <= run_rem_ff;
            wait_pri_ff[free_slot] <= run_pri_ff;
            wait_arr_ff[free_slot] <= run_arr_ff;
         end else begin
            wait_id_ff[free_slot]  <= in_id_ff;
            wait_rem_ff[free_slot] <= in_run_ff;
            wait_pri_ff[free_slot] <= in_pri_ff;
            wait_arr_ff[free_slot] <= in_arr_ff;
         end
      end
      if (emit) begin
         held_id_ff   <= emit_id;
         held_time_ff <= emit_time;
         held_drop_ff <= emit_drop;
      end
      if (emit && held_valid_ff) begin
         out_id_ff   <= held_id_ff;
         out_time_ff <= held_time_ff;
         out_drop_ff <= held_drop_ff;
         out_last_ff <= 1'b0;
      end else if (cmd.flush) begin
         out_id_ff   <= held_id_ff;
         out_time_ff <= held_time_ff;
         out_drop_ff <= held_drop_ff;
         out_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         run_valid_ff  <= 1'b0;
         run_id_ff     <= '0;
         run_rem_ff    <= '0;
         run_pri_ff    <= '0;
         run_arr_ff    <= '0;
         wait_valid_ff <= '0;
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.finish) begin
            now_ff        <= fin_time;
            idx_ff        <= '0;
            best_valid_ff <= 1'b0;
         end
         if (cmd.reduce) run_rem_ff <= run_rem_ff - elapsed_ff[15:0];
         if (cmd.step) begin
            idx_ff <= idx_ff + SLOT_W'(1);
            if (wait_valid_ff[idx_ff]) best_valid_ff <= 1'b1;
         end
         if (cmd.dispatch) begin
            run_valid_ff <= best_valid_ff;
            if (best_valid_ff) begin
               run_id_ff              <= best_id_ff;
               run_rem_ff             <= best_rem_ff;
               run_pri_ff             <= best_pri_ff;
               run_arr_ff             <= best_arr_ff;
               wait_valid_ff[best_ff] <= 1'b0;
            end
         end
         if (cmd.place) begin
            now_ff <= target_ff;
            if (!run_valid_ff || (!full && in_pri_ff > run_pri_ff)) begin
               run_valid_ff <= 1'b1;
               run_id_ff    <= in_id_ff;
               run_rem_ff   <= in_run_ff;
               run_pri_ff   <= in_pri_ff;
               run_arr_ff   <= in_arr_ff;
            end
            if (run_valid_ff && !full) wait_valid_ff[free_slot] <= 1'b1;
         end
         if (emit)            held_valid_ff <= 1'b1;
         else if (cmd.flush)  held_valid_ff <= 1'b0;
         if ((emit && held_valid_ff) || cmd.flush) out_valid_ff <= 1'b1;
         else if (rsp_if.ready)                    out_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.done_id     = out_id_ff;
   assign rsp_if.finish_time = out_time_ff;
   assign rsp_if.last        = out_last_ff;
   assign rsp_if.dropped     = out_drop_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (emit && held_valid_ff) |-> out_free) else $error("result overwritten");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !run_valid_ff |-> (wait_valid_ff == '0)) else $error("jobs wait on idle processor");
   a_reduce_fit: assert property (@(posedge clock) disable iff (reset)
      cmd.reduce |-> (elapsed_ff < {16'd0, run_rem_ff})) else $error("bad reduce");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (out_valid_ff && out_last_ff && !held_valid_ff))
      else $error("flush lost");

endmodule

/* hw/rtl/preemptive_priority_job_scheduler.sv */
// Top level of the preemptive priority job scheduler.
// Depends on ppjs_pkg, ppjs_req_if, ppjs_rsp_if, ppjs_ctrl, ppjs_dp.
//
// Usage:
//  req_if carries one item: a job arrival (req_type 0) or a drain (req_type 1).
//  rsp_if carries completions (done_id, finish_time) and drop notices; the
//  last result caused by an item has last set. An item causing no result
//  produces nothing on rsp_if.
//  One item is worked at a time; req_if.ready is high only while idle.
//  A running job that cannot finish within the elapsed time absorbs it; each
//  completion is followed by a one-slot-per-cycle search over the waiting
//  slots to pick the next job (priority, then arrival, then id).
//  Results pass through a holding register and an output register, so the
//  block keeps working while a result waits; when the receiver stalls with
//  both full, the sequencer waits until rsp_if.ready frees a stage.
//  Reset (synchronous, active high) clears time, the running job and all
//  waiting slots at once; no clearing pass is needed. req_if.ready stays low
//  while reset is high.
module preemptive_priority_job_scheduler (
   input logic        clock,
   input logic        reset,
   ppjs_req_if.sink   req_if,
   ppjs_rsp_if.source rsp_if
);
   import ppjs_pkg::*;

   ppjs_cmd_type  cmd;
   ppjs_stat_type st;

   // sequencer
   ppjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // state, search and result staging
   ppjs_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .st     (st)
   );

endmodule
